>>> design/efa_pkg.sv
package efa_pkg;

    // field widths fixed by the interface
    localparam int OP_W     = 2;
    localparam int COORD_W  = 15;
    localparam int INDEX_W  = 16;
    localparam int OUT_W    = 16;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 1;

    // opcodes
    localparam logic [OP_W-1:0] OP_EVENT = 2'd0;
    localparam logic [OP_W-1:0] OP_SWAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DROP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // frame dimension after reset
    localparam logic [CFG_W-1:0] DIM_RESET = 9'd256;

    // command queue occupancy
    localparam logic [1:0] Q_EMPTY = 2'd0;
    localparam logic [1:0] Q_FULL  = 2'd2;

    // what the back end has to do with a queued command
    typedef enum logic [1:0] {
        CMD_EVENT = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SWAP  = 2'd2,
        CMD_REPLY = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [STATUS_W-1:0]  status;
    } t_cmd;

endpackage

>>> design/efa_front.sv
module efa_front #(
    parameter int MAX_ROWS = 256,
    parameter int MAX_COLS = 256,
    parameter int ADDR_W   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_q_full,
    input  logic                            i_init_busy,
    output logic                            o_busy,
    input  logic                            i_cfg_we,
    input  logic [efa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [efa_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic [efa_pkg::OP_W-1:0]        i_opcode,
    input  logic [efa_pkg::COORD_W-1:0]     i_x,
    input  logic [efa_pkg::COORD_W-1:0]     i_y,
    input  logic [efa_pkg::INDEX_W-1:0]     i_pixel_index,
    output logic                            o_push,
    output efa_pkg::t_cmd                   o_cmd,
    output logic [ADDR_W-1:0]               o_addr
);

    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int RDIM_W = (ROW_W > efa_pkg::CFG_W) ? ROW_W : efa_pkg::CFG_W;
    localparam int CDIM_W = (COL_W > efa_pkg::CFG_W) ? COL_W : efa_pkg::CFG_W;
    localparam int AREA_W = ROW_W + COL_W;
    localparam int CMP_W  = (AREA_W > efa_pkg::INDEX_W) ? AREA_W : efa_pkg::INDEX_W;
    localparam int XCMP_W = (ROW_W > efa_pkg::COORD_W) ? ROW_W : efa_pkg::COORD_W;
    localparam int YCMP_W = (COL_W > efa_pkg::COORD_W) ? COL_W : efa_pkg::COORD_W;

    logic [efa_pkg::CFG_W-1:0] r_frame_rows;
    logic [efa_pkg::CFG_W-1:0] r_frame_cols;
    logic [RDIM_W-1:0]         rows_ext;
    logic [CDIM_W-1:0]         cols_ext;
    logic [ROW_W-1:0]          rows;
    logic [COL_W-1:0]          cols;
    logic [AREA_W-1:0]         area;
    logic [AREA_W-1:0]         ev_addr;
    logic                      ev_out;
    logic                      rd_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_rows <= efa_pkg::DIM_RESET;
            r_frame_cols <= efa_pkg::DIM_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == efa_pkg::REG_ROWS) begin
                r_frame_rows <= i_cfg_wdata;
            end
            if (i_cfg_index == efa_pkg::REG_COLS) begin
                r_frame_cols <= i_cfg_wdata;
            end
        end
    end

    // frame dimensions clamped to one .. maximum
    always_comb begin
        rows_ext = RDIM_W'(r_frame_rows);
        cols_ext = CDIM_W'(r_frame_cols);
        if (r_frame_rows == '0) begin
            rows = ROW_W'(1);
        end else if (rows_ext > RDIM_W'(MAX_ROWS)) begin
            rows = ROW_W'(MAX_ROWS);
        end else begin
            rows = ROW_W'(rows_ext);
        end
        if (r_frame_cols == '0) begin
            cols = COL_W'(1);
        end else if (cols_ext > CDIM_W'(MAX_COLS)) begin
            cols = COL_W'(MAX_COLS);
        end else begin
            cols = COL_W'(cols_ext);
        end
    end

    // bounds checks and linear pixel address
    always_comb begin
        area    = AREA_W'(rows) * AREA_W'(cols);
        ev_out  = (XCMP_W'(i_x) >= XCMP_W'(rows)) || (YCMP_W'(i_y) >= YCMP_W'(cols));
        rd_out  = CMP_W'(i_pixel_index) >= CMP_W'(area);
        ev_addr = AREA_W'(ROW_W'(i_x)) * AREA_W'(cols) + AREA_W'(COL_W'(i_y));
    end

    // accept handshake
    assign o_busy = !i_rst_n || i_q_full || i_init_busy;
    assign o_push = i_start && !o_busy;

    // classify the command for the back end
    always_comb begin
        o_cmd.kind   = efa_pkg::CMD_REPLY;
        o_cmd.status = efa_pkg::ST_OK;
        o_addr       = '0;
        case (i_opcode)
            efa_pkg::OP_EVENT: begin
                if (ev_out) begin
                    o_cmd.status = efa_pkg::ST_DROP;
                end else begin
                    o_cmd.kind = efa_pkg::CMD_EVENT;
                    o_addr     = ADDR_W'(ev_addr);
                end
            end
            efa_pkg::OP_SWAP: begin
                o_cmd.kind = efa_pkg::CMD_SWAP;
            end
            efa_pkg::OP_READ: begin
                if (rd_out) begin
                    o_cmd.status = efa_pkg::ST_RANGE;
                end else begin
                    o_cmd.kind = efa_pkg::CMD_READ;
                    o_addr     = ADDR_W'(CMP_W'(i_pixel_index));
                end
            end
            default: begin
                o_cmd.kind = efa_pkg::CMD_REPLY;
            end
        endcase
    end

endmodule

>>> design/efa_queue.sv
module efa_queue #(
    parameter int ADDR_W = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  efa_pkg::t_cmd       i_cmd,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output efa_pkg::t_cmd       o_cmd,
    output logic [ADDR_W-1:0]   o_addr
);

    efa_pkg::t_cmd     r_cmd  [2];
    logic [ADDR_W-1:0] r_addr [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_count;
    logic [1:0]        n_count;

    assign o_valid = (r_count != efa_pkg::Q_EMPTY);
    assign o_full  = (r_count == efa_pkg::Q_FULL);
    assign o_cmd   = r_cmd[r_rd];
    assign o_addr  = r_addr[r_rd];

    // occupancy update
    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= efa_pkg::Q_EMPTY;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_cmd[r_wr]  <= i_cmd;
            r_addr[r_wr] <= i_addr;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into a full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from an empty command queue");

endmodule

>>> design/efa_back.sv
module efa_back #(
    parameter int DEPTH      = 65536,
    parameter int ADDR_W     = 16,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    input  efa_pkg::t_cmd                   i_cmd,
    input  logic [ADDR_W-1:0]               i_addr,
    output logic                            o_pop,
    output logic                            o_init_busy,
    output logic                            o_valid,
    output logic [efa_pkg::OUT_W-1:0]       o_count,
    output logic [efa_pkg::STATUS_W-1:0]    o_status
);

    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [4:0] {
        S_INIT  = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RMW   = 5'b00100,
        S_READ  = 5'b01000,
        S_CLEAR = 5'b10000
    } t_state;

    t_state                         r_state;
    t_state                         n_state;
    logic                           r_active;
    logic                           n_active;
    logic [ADDR_W-1:0]              r_clr;
    logic [ADDR_W-1:0]              n_clr;
    logic [ADDR_W-1:0]              r_addr;
    logic [ADDR_W-1:0]              n_addr;
    logic                           r_out_valid;
    logic                           n_out_valid;
    logic [efa_pkg::OUT_W-1:0]      r_count;
    logic [efa_pkg::OUT_W-1:0]      n_count;
    logic [efa_pkg::STATUS_W-1:0]   r_status;
    logic [efa_pkg::STATUS_W-1:0]   n_status;

    logic [COUNT_BITS-1:0]          r_bank_a [DEPTH];
    logic [COUNT_BITS-1:0]          r_bank_b [DEPTH];
    logic [COUNT_BITS-1:0]          r_rd_a;
    logic [COUNT_BITS-1:0]          r_rd_b;
    logic                           we_a;
    logic                           we_b;
    logic [ADDR_W-1:0]              wr_addr;
    logic [COUNT_BITS-1:0]          wdata;
    logic [COUNT_BITS-1:0]          acc_data;
    logic [COUNT_BITS-1:0]          snap_data;
    logic [COUNT_BITS-1:0]          inc_data;

    assign o_init_busy = (r_state == S_INIT);
    assign o_valid     = r_out_valid;
    assign o_count     = r_count;
    assign o_status    = r_status;

    // bank a holds the running counts while r_active is low
    assign acc_data  = r_active ? r_rd_b : r_rd_a;
    assign snap_data = r_active ? r_rd_a : r_rd_b;
    assign inc_data  = (acc_data == COUNT_MAX) ? acc_data : acc_data + COUNT_BITS'(1);

    // command sequencer
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_clr       = r_clr;
        n_addr      = r_addr;
        n_out_valid = 1'b0;
        n_count     = r_count;
        n_status    = r_status;
        o_pop       = 1'b0;
        we_a        = 1'b0;
        we_b        = 1'b0;
        wr_addr     = r_addr;
        wdata       = '0;
        case (r_state)
            S_INIT: begin
                we_a    = 1'b1;
                we_b    = 1'b1;
                wr_addr = r_clr;
                n_clr   = r_clr + ADDR_W'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop  = 1'b1;
                    n_addr = i_addr;
                    case (i_cmd.kind)
                        efa_pkg::CMD_EVENT: begin
                            n_state = S_RMW;
                        end
                        efa_pkg::CMD_READ: begin
                            n_state = S_READ;
                        end
                        efa_pkg::CMD_SWAP: begin
                            n_active    = !r_active;
                            n_clr       = '0;
                            n_state     = S_CLEAR;
                            n_out_valid = 1'b1;
                            n_count     = '0;
                            n_status    = efa_pkg::ST_OK;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                            n_count     = '0;
                            n_status    = i_cmd.status;
                        end
                    endcase
                end
            end
            S_RMW: begin
                we_a        = !r_active;
                we_b        = r_active;
                wdata       = inc_data;
                n_out_valid = 1'b1;
                n_count     = efa_pkg::OUT_W'(inc_data);
                n_status    = efa_pkg::ST_OK;
                n_state     = S_IDLE;
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_count     = efa_pkg::OUT_W'(snap_data);
                n_status    = efa_pkg::ST_OK;
                n_state     = S_IDLE;
            end
            S_CLEAR: begin
                we_a    = !r_active;
                we_b    = r_active;
                wr_addr = r_clr;
                n_clr   = r_clr + ADDR_W'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
                n_clr   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_active    <= 1'b0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_count  <= n_count;
        r_status <= n_status;
    end

    // count banks, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (we_a) begin
            r_bank_a[wr_addr] <= wdata;
        end
        r_rd_a <= r_bank_a[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            r_bank_b[wr_addr] <= wdata;
        end
        r_rd_b <= r_bank_b[i_addr];
    end

    a_rmw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMW) |=> o_valid)
        else $error("event update gave no result");

    a_swap_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_q_valid && i_cmd.kind == efa_pkg::CMD_SWAP)
        |=> (r_state == S_CLEAR && r_active != $past(r_active)))
        else $error("swap did not flip banks and start clearing");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_pop)
        else $error("command taken while the back end is occupied");

    a_init_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !r_out_valid)
        else $error("result issued during the reset clear");

endmodule

>>> design/event_frame_accumulator.sv
// channel    | ports                                         | direction | handshake
// -----------+-----------------------------------------------+-----------+--------------------
// command    | i_opcode, i_x, i_y, i_pixel_index             | in        | start high, busy low
// result     | o_count, o_status                             | out       | o_valid, one cycle
// config     | i_cfg_index, i_cfg_wdata                      | in        | i_cfg_we
//
// a command queue of two entries sits between the classifier and the bank sequencer
// the sequencer handles an event as a bank read, then a write back, and a read as a
// bank read alone; a swap or a dropped command needs no bank read
// a swap is followed by clearing all MAX_ROWS*MAX_COLS entries of the new accumulating bank,
// during which queued commands wait and busy rises once the queue is full
// after reset both banks are cleared over all MAX_ROWS*MAX_COLS entries with busy held high
// results cannot be stalled by the receiver; each o_valid strobe is one transfer
module event_frame_accumulator #(
    parameter int MAX_ROWS   = 256,
    parameter int MAX_COLS   = 256,
    parameter int COUNT_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [efa_pkg::OP_W-1:0]        i_opcode,
    input  logic [efa_pkg::COORD_W-1:0]     i_x,
    input  logic [efa_pkg::COORD_W-1:0]     i_y,
    input  logic [efa_pkg::INDEX_W-1:0]     i_pixel_index,
    input  logic                            i_cfg_we,
    input  logic [efa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [efa_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                            o_valid,
    output logic [efa_pkg::OUT_W-1:0]       o_count,
    output logic [efa_pkg::STATUS_W-1:0]    o_status
);

    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_valid;
    logic               init_busy;
    efa_pkg::t_cmd      front_cmd;
    efa_pkg::t_cmd      q_cmd;
    logic [ADDR_W-1:0]  front_addr;
    logic [ADDR_W-1:0]  q_addr;

    // accept and classify
    efa_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_q_full      (q_full),
        .i_init_busy   (init_busy),
        .o_busy        (busy),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_opcode      (i_opcode),
        .i_x           (i_x),
        .i_y           (i_y),
        .i_pixel_index (i_pixel_index),
        .o_push        (push),
        .o_cmd         (front_cmd),
        .o_addr        (front_addr)
    );

    // command queue
    efa_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_addr  (front_addr),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (q_cmd),
        .o_addr  (q_addr)
    );

    // bank sequencer and result register
    efa_back #(
        .DEPTH      (DEPTH),
        .ADDR_W     (ADDR_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .i_addr      (q_addr),
        .o_pop       (pop),
        .o_init_busy (init_busy),
        .o_valid     (o_valid),
        .o_count     (o_count),
        .o_status    (o_status)
    );

endmodule
